/* hdl/frwm_pkg.sv */
// Package for the frame rate window meter: field widths, rate numerator,
// mode codes and the packed transaction types of both channels.
// No dependencies.
package frwm_pkg;

    localparam int VALUE_W         = 48;
    localparam int RATE_W          = 28;
    localparam int DEF_NUM_SAMPLES = 16;

    // 1000000 in 20.8 fixed point; also the largest rate the block can give
    localparam logic [RATE_W-1:0] RATE_NUM = 28'd256000000;

    localparam logic MODE_STAMP = 1'b0;
    localparam logic MODE_IVL   = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [VALUE_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [RATE_W-1:0] sample_rate;
        logic [RATE_W-1:0] average_rate;
        logic              window_done;
    } t_out;

endpackage

/* hdl/frwm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frwm_ram #(
    parameter int WIDTH  = 28,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/frame_rate_window_meter.sv */
// Frame rate window meter, top level: interval forming, bit-serial divider,
// sample ring with running sum, output register.
// Depends on frwm_pkg and frwm_ram.
//
//  channel   | valid    | stall    | payload              | direction
//  ----------+----------+----------+----------------------+----------
//  event in  | i_valid  | o_stall  | i_data (t_in)        | into block
//  result    | o_valid  | i_stall  | o_data (t_out)       | out of block
//
// One event goes through these steps from acceptance to the next point of
// acceptance when the result is taken at once: form the interval, run the
// restoring divider for the rate, update the ring, run the same divider for
// the average, load the output register. The divider is shared and gives
// one quotient bit per cycle.
// Reset (i_rst_n low, synchronous) clears the sequencer, the last timestamp,
// the ring write slot, the running sum and the per-slot valid bits; a slot
// not yet written reads as zero, so no clearing pass is needed.
// A stalled result is held in the output register; the next result then
// waits in S_DONE with o_stall high until the register frees up.
module frame_rate_window_meter #(
    parameter int NUM_SAMPLES = frwm_pkg::DEF_NUM_SAMPLES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  frwm_pkg::t_in  i_data,
    output logic           o_valid,
    output frwm_pkg::t_out o_data,
    input  logic           i_stall
);

    localparam int VALUE_W = frwm_pkg::VALUE_W;
    localparam int RATE_W  = frwm_pkg::RATE_W;
    localparam int IDX_W   = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
    // each slot is below 2^RATE_W, so NUM_SAMPLES of them fit in SUM_W bits
    localparam int SUM_W   = RATE_W + IDX_W;
    localparam int CNT_W   = $clog2(RATE_W);

    localparam logic [IDX_W-1:0]   LAST_SLOT = IDX_W'(NUM_SAMPLES - 1);
    localparam logic [VALUE_W-1:0] DIVISOR_N = VALUE_W'(NUM_SAMPLES);
    localparam logic [CNT_W-1:0]   LAST_BIT  = CNT_W'(RATE_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RATE,
        S_SUM,
        S_AVG,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [VALUE_W-1:0]   r_prev;
    logic [VALUE_W-1:0]   r_div;
    logic [VALUE_W-1:0]   r_rem;
    logic [RATE_W-1:0]    r_quo;
    logic [CNT_W-1:0]     r_cnt;
    logic [IDX_W-1:0]     r_slot;
    logic [NUM_SAMPLES-1:0] r_vld;
    logic [SUM_W-1:0]     r_sum;
    logic [RATE_W-1:0]    r_rate;
    logic                 r_wrap;
    logic                 r_out_valid;
    frwm_pkg::t_out       r_out;

    logic [VALUE_W-1:0]   w_diff;
    logic                 w_back;
    logic [VALUE_W-1:0]   n_div;
    logic [VALUE_W:0]     w_trial;
    logic [VALUE_W:0]     w_trial_sub;
    logic                 w_fits;
    logic [VALUE_W-1:0]   n_rem;
    logic [RATE_W-1:0]    n_quo;
    logic [RATE_W-1:0]    w_ram_rdata;
    logic [RATE_W-1:0]    w_old;
    logic [SUM_W-1:0]     n_sum;
    logic                 w_slot_last;
    logic [IDX_W-1:0]     n_slot;
    logic                 w_out_free;

    // Interval: a timestamp going backwards counts as one, and so does zero.
    always_comb begin
        w_diff = i_data.value - r_prev;
        w_back = i_data.value < r_prev;
        if (i_data.mode == frwm_pkg::MODE_IVL) begin
            n_div = i_data.value;
        end else if (w_back) begin
            n_div = VALUE_W'(1);
        end else begin
            n_div = w_diff;
        end
        if (n_div == '0) begin
            n_div = VALUE_W'(1);
        end
    end

    // One restoring step: bring down the next numerator bit, try the divisor.
    always_comb begin
        w_trial     = {r_rem, r_quo[RATE_W-1]};
        w_trial_sub = w_trial - {1'b0, r_div};
        w_fits      = w_trial >= {1'b0, r_div};
        n_rem       = w_fits ? w_trial_sub[VALUE_W-1:0] : w_trial[VALUE_W-1:0];
        n_quo       = {r_quo[RATE_W-2:0], w_fits};
    end

    // Ring update: swap the oldest slot out of the running sum.
    always_comb begin
        w_old       = r_vld[r_slot] ? w_ram_rdata : '0;
        n_sum       = r_sum - SUM_W'(w_old) + SUM_W'(r_quo);
        w_slot_last = (r_slot == LAST_SLOT);
        n_slot      = w_slot_last ? '0 : r_slot + IDX_W'(1);
    end

    assign w_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_slot      <= '0;
            r_vld       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once the far side has taken it, unless the
            // next one loads in the same cycle
            if (r_out_valid && !i_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_data.mode == frwm_pkg::MODE_STAMP) begin
                            r_prev <= i_data.value;
                        end
                        r_div   <= n_div;
                        r_rem   <= '0;
                        r_quo   <= frwm_pkg::RATE_NUM;
                        r_cnt   <= LAST_BIT;
                        r_state <= S_RATE;
                    end
                end
                S_RATE: begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_rate        <= r_quo;
                    r_sum         <= n_sum;
                    r_vld[r_slot] <= 1'b1;
                    r_slot        <= n_slot;
                    r_wrap        <= w_slot_last;
                    // sum < NUM_SAMPLES * 2^RATE_W, so the upper part starts
                    // as a remainder below the divisor and RATE_W steps suffice
                    r_div   <= DIVISOR_N;
                    r_rem   <= VALUE_W'(n_sum[SUM_W-1:RATE_W]);
                    r_quo   <= n_sum[RATE_W-1:0];
                    r_cnt   <= LAST_BIT;
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid        <= 1'b1;
                        r_out.sample_rate  <= r_rate;
                        r_out.average_rate <= r_quo;
                        r_out.window_done  <= r_wrap;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    frwm_ram #(
        .WIDTH  (RATE_W),
        .DEPTH  (NUM_SAMPLES),
        .ADDR_W (IDX_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == S_SUM),
        .i_waddr (r_slot),
        .i_wdata (r_quo),
        .i_raddr (r_slot),
        .o_rdata (w_ram_rdata)
    );

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* hdl/frwm_chk.sv */
// Port-level checker for the frame rate window meter, and its bind.
// Depends on frwm_pkg and frame_rate_window_meter.
module frwm_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input frwm_pkg::t_in  i_data,
    input logic           o_valid,
    input frwm_pkg::t_out o_data,
    input logic           i_stall
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // an accepted transaction keeps the block busy on the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("block not busy after accepting an event");

    // a result cannot appear on the cycle after acceptance
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |=> !o_valid)
        else $error("result appeared too early");

    // rates never exceed 1000000 events per second
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.sample_rate <= frwm_pkg::RATE_NUM
                 && o_data.average_rate <= frwm_pkg::RATE_NUM)
        else $error("rate out of range");

    // reset clears the output valid flag and leaves the block idle
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output or busy state survived reset");

endmodule

bind frame_rate_window_meter frwm_chk u_frwm_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .o_data  (o_data),
    .i_stall (i_stall)
);

/* sim/frwm_rate_checker.sv */
`timescale 1ns / 100ps
// Rate checker for the frame rate window meter: watches both channels, predicts
// each result from the accepted events and compares it with what comes out.
// Depends on frwm_pkg.
module frwm_rate_checker #(
    parameter int NUM_SAMPLES = frwm_pkg::DEF_NUM_SAMPLES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ev_valid,
    input  logic           i_ev_stall,
    input  frwm_pkg::t_in  i_ev_data,
    input  logic           i_res_valid,
    input  logic           i_res_stall,
    input  frwm_pkg::t_out i_res_data,
    output int             o_fail_count,
    output int             o_pending
);
    import frwm_pkg::*;

    // own copy of the meter state
    logic [RATE_W-1:0]  ring_q [NUM_SAMPLES];
    int unsigned        slot_q;
    longint unsigned    sum_q;
    logic [VALUE_W-1:0] stamp_q;

    t_out rate_results_due [$];
    int   fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    // Work out the result of one event and advance the state.
    function automatic t_out next_rate_result(input t_in ev);
        longint unsigned span;
        longint unsigned rate;
        t_out            res;
        if (ev.mode == MODE_STAMP) begin
            span    = (ev.value < stamp_q) ? 64'd1 : 64'(ev.value - stamp_q);
            stamp_q = ev.value;
        end else begin
            span = 64'(ev.value);
        end
        if (span == 0) span = 1;
        rate = 64'(RATE_NUM) / span;
        sum_q = sum_q - 64'(ring_q[slot_q]) + rate;
        ring_q[slot_q] = rate[RATE_W-1:0];
        slot_q = (slot_q + 1 >= NUM_SAMPLES) ? 0 : slot_q + 1;
        res.sample_rate  = rate[RATE_W-1:0];
        res.average_rate = RATE_W'(sum_q / NUM_SAMPLES);
        res.window_done  = (slot_q == 0);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SAMPLES; k++) ring_q[k] = '0;
            slot_q  = 0;
            sum_q   = 0;
            stamp_q = '0;
            rate_results_due.delete();
        end else begin
            if (i_ev_valid && !i_ev_stall)
                rate_results_due.push_back(next_rate_result(i_ev_data));
            if (i_res_valid && !i_res_stall) begin
                got = i_res_data;
                if (rate_results_due.size() == 0) begin
                    $error("result with nothing due: sample_rate %0d average_rate %0d",
                           got.sample_rate, got.average_rate);
                    fail_cnt++;
                end else begin
                    want = rate_results_due.pop_front();
                    if (got.sample_rate !== want.sample_rate) begin
                        $error("sample_rate: expected %0d, got %0d",
                               want.sample_rate, got.sample_rate);
                        fail_cnt++;
                    end
                    if (got.average_rate !== want.average_rate) begin
                        $error("average_rate: expected %0d, got %0d",
                               want.average_rate, got.average_rate);
                        fail_cnt++;
                    end
                    if (got.window_done !== want.window_done) begin
                        $error("window_done: expected %0b, got %0b",
                               want.window_done, got.window_done);
                        fail_cnt++;
                    end
                end
            end
        end
        o_pending <= rate_results_due.size();
    end

endmodule

/* sim/frame_rate_window_meter_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the frame rate window meter: drives frame events and the
// result stall, and gives the verdict. Depends on frwm_pkg, the block and
// frwm_rate_checker.
module frame_rate_window_meter_tb;
    import frwm_pkg::*;

    localparam int NUM_SAMPLES      = DEF_NUM_SAMPLES;
    localparam int RANDOM_EVENTS    = 1700;
    localparam int LONG_HOLD_CYCLES = 600;   // about ten events' worth of work
    localparam int SETTLE_CYCLES    = 150;   // over two event latencies

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    t_out o_data;
    logic i_stall;

    int fail_count;
    int pending;

    // handshake between stimulus and result sink for the long hold-off:
    // each side writes only its own counter
    int hold_asked  = 0;
    int hold_served = 0;

    logic [VALUE_W-1:0] stamp_sent = '0;

    frame_rate_window_meter #(
        .NUM_SAMPLES(NUM_SAMPLES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .o_data (o_data),
        .i_stall(i_stall)
    );

    frwm_rate_checker #(
        .NUM_SAMPLES(NUM_SAMPLES)
    ) u_rate_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ev_valid  (i_valid),
        .i_ev_stall  (o_stall),
        .i_ev_data   (i_data),
        .i_res_valid (o_valid),
        .i_res_stall (i_stall),
        .i_res_data  (o_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit, well above the slowest correct run: about 1750 events, each
    // with its share of work, plus sender gaps between bursts, some receiver
    // stall and the long hold-off.
    initial begin
        #30_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Offer one event and hold it until the block takes it. Returns just
    // after the accepting edge, with valid still high, so a following call
    // keeps the channel busy without a bubble.
    task automatic offer_event(input logic mode, input logic [VALUE_W-1:0] value);
        t_in ev;
        ev.mode  = mode;
        ev.value = value;
        if (mode == MODE_STAMP) stamp_sent = value;
        i_valid <= 1'b1;
        i_data  <= ev;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Lower valid and hold off until every due result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Result sink: stall in one of four styles, picked anew at random whenever the current one runs out,
    // with a long hold-off whenever the stimulus asks for one.
    initial begin
        int style;
        int style_left;
        int cyc;
        style      = 0;
        style_left = 0;
        cyc        = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_asked != hold_served) begin
                // hold the result back so the block fills and stalls its input
                i_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                hold_served++;
            end else begin
                if (style_left == 0) begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(50, 400);
                end
                style_left--;
                case (style)
                    0: begin
                        i_stall <= 1'b0;                          // take at once
                    end
                    1: begin
                        i_stall <= ($urandom_range(0, 3) == 0);   // light stall
                    end
                    2: begin
                        i_stall <= ($urandom_range(0, 3) != 0);   // heavy stall
                    end
                    default: begin
                        i_stall <= ((cyc % 7) < 3);              // fixed rhythm
                    end
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int burst_left;
        int gap;
        int pick;
        bit mid_drained;
        logic [63:0] wide;

        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed events, back to back
        offer_event(MODE_STAMP, 48'd16667);          // first stamp is its own interval
        offer_event(MODE_STAMP, 48'd33334);
        offer_event(MODE_STAMP, 48'd33334);          // zero interval taken as one
        offer_event(MODE_STAMP, 48'd20000);          // stamp going backwards
        offer_event(MODE_STAMP, 48'd0);              // backwards to zero
        offer_event(MODE_STAMP, 48'd0);
        offer_event(MODE_IVL,   48'd0);              // zero interval in interval mode
        offer_event(MODE_IVL,   48'd1);
        offer_event(MODE_IVL,   48'd2);
        offer_event(MODE_IVL,   48'd3);
        offer_event(MODE_IVL,   48'd255999999);
        offer_event(MODE_IVL,   48'd256000000);      // rate of exactly one
        offer_event(MODE_IVL,   48'd256000001);      // rate truncates to zero
        offer_event(MODE_IVL,   48'hFFFF_FFFF_FFFF);
        offer_event(MODE_STAMP, 48'd50);             // intervals left last stamp alone
        offer_event(MODE_STAMP, 48'hFFFF_FFFF_FFFF); // nearly the widest interval
        offer_event(MODE_STAMP, 48'hFFFF_FFFF_FFFF);
        offer_event(MODE_STAMP, 48'h8000_0000_0000);
        offer_event(MODE_IVL,   48'd16667);
        offer_event(MODE_IVL,   48'd1000000);
        repeat (4) offer_event(MODE_IVL, 48'd1);     // the ring wrapped on the sixteenth event

        // Pause until everything is back
        drain_results();

        // Long hold-off at the receiver while events keep coming
        hold_asked++;
        repeat (12) offer_event(MODE_IVL, 48'($urandom_range(1, 70000)));
        drain_results();

        // Random events in bursts; mostly plausible frame timing, some noise
        burst_left  = 0;
        mid_drained = 1'b0;
        for (int n = 0; n < RANDOM_EVENTS; n++) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                if (!mid_drained && n >= RANDOM_EVENTS / 2) begin
                    drain_results();
                    mid_drained = 1'b1;
                end else if (gap != 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            pick = $urandom_range(0, 99);
            wide = {$urandom, $urandom};
            if (pick < 40)
                offer_event(MODE_STAMP, stamp_sent + 48'($urandom_range(1, 70000)));
            else if (pick < 70)
                offer_event(MODE_IVL, 48'($urandom_range(1, 70000)));
            else if (pick < 78)
                offer_event(MODE_IVL, 48'($urandom_range(0, 300)));
            else if (pick < 88)
                offer_event(wide[63], wide[VALUE_W-1:0]);
            else if (pick < 94)
                offer_event(MODE_STAMP, stamp_sent - 48'($urandom_range(0, 1000)));
            else
                offer_event(MODE_IVL, 48'($urandom_range(200000000, 300000000)));
        end

        // Let the last results out, then watch for strays
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
